/* rtl/b64s_pkg.sv */
// ----------------------------------------------------------------------------
// b64s_pkg
// Types, constants and the alphabet lookup for the sample Base64 encoder.
// ----------------------------------------------------------------------------
package b64s_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CHAR_W    = 7;
  localparam int SEXTET_W  = 6;
  localparam int BYTE_W    = 8;
  localparam int GROUP_W   = 3 * BYTE_W;

  // job queue between front and back
  localparam int Q_DEPTH   = 2;
  localparam int QPTR_W    = $clog2(Q_DEPTH);
  localparam int QCNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;  // '='

  // pending byte count codes
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  // number of '=' characters that close a group
  localparam logic [1:0] PAD_NONE  = 2'd0;
  localparam logic [1:0] PAD_ONE   = 2'd1;
  localparam logic [1:0] PAD_TWO   = 2'd2;

  // one group of three bytes, missing bytes are zero
  typedef struct packed {
    logic [GROUP_W-1:0] bytes;
    logic [1:0]         npad;
  } group_t;

  // work for one sample: one or two groups of four characters
  typedef struct packed {
    group_t g0;
    logic   g1_vld;
    group_t g1;
  } job_t;

  // standard alphabet lookup
  function automatic logic [CHAR_W-1:0] b64_char(input logic [SEXTET_W-1:0] v);
    logic [CHAR_W-1:0] w;
    w = {1'b0, v};
    if (v < 6'd26)       b64_char = w + 7'd65;
    else if (v < 6'd52)  b64_char = w + 7'd71;
    else if (v < 6'd62)  b64_char = w - 7'd4;
    else if (v == 6'd62) b64_char = 7'd43;
    else                 b64_char = 7'd47;
  endfunction

endpackage

/* rtl/b64s_if.sv */
// ----------------------------------------------------------------------------
// b64s channel interfaces
// Ready/valid channels for samples in and characters out.
// ----------------------------------------------------------------------------
interface b64s_in_if import b64s_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface b64s_out_if import b64s_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

/* rtl/base64_sample_encoder.sv */
// ----------------------------------------------------------------------------
// base64_sample_encoder
// Base64 encoder for a stream of 16-bit samples, high byte first.
// ----------------------------------------------------------------------------
// path: the first character of a sample beat passes through a job queue entry and the output register
// throughput: one sample beat a cycle while the two-entry job queue has room;
//   the back end gives one character a cycle while a job waits and the output is ready;
//   a sample yields 0, 4 or 8 characters
// reset: synchronous active-low rst_n clears pending count, queue and output
module base64_sample_encoder import b64s_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  b64s_in_if.sink    in_bus,
  b64s_out_if.source out_bus
);

  logic    q_push, q_full, q_pop, q_empty;
  job_t    push_job, head_job;

  // front: pending bytes and job building
  b64s_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  // job queue
  b64s_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  // back: character emission
  b64s_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .job     (head_job),
    .job_vld (!q_empty),
    .job_pop (q_pop),
    .out_bus (out_bus)
  );

endmodule

/* rtl/b64s_front.sv */
// ----------------------------------------------------------------------------
// b64s_front
// Takes sample beats, tracks pending bytes and queues groups to encode.
// ----------------------------------------------------------------------------
module b64s_front import b64s_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  b64s_in_if.sink        in_bus,
  input  logic           q_full,
  output logic           q_push,
  output job_t           q_job
);

  logic [1:0]        count_r, count_nxt;
  logic [BYTE_W-1:0] b0_r, b0_nxt;
  logic [BYTE_W-1:0] b1_r, b1_nxt;
  logic [BYTE_W-1:0] hi, lo;
  logic              accept;
  logic              has_work;

  assign in_bus.ready = !q_full;
  assign accept       = in_bus.valid && in_bus.ready;
  assign hi           = in_bus.sample[SAMPLE_W-1:BYTE_W];
  assign lo           = in_bus.sample[BYTE_W-1:0];

  // classify the beat against the pending bytes
  always_comb begin
    count_nxt = count_r;
    b0_nxt    = b0_r;
    b1_nxt    = b1_r;
    has_work  = 1'b0;
    q_job     = '0;
    unique case (count_r)
      PEND_ONE: begin
        has_work       = 1'b1;
        q_job.g0.bytes = {b0_r, hi, lo};
        q_job.g0.npad  = PAD_NONE;
        count_nxt      = PEND_NONE;
      end
      PEND_TWO: begin
        has_work       = 1'b1;
        q_job.g0.bytes = {b0_r, b1_r, hi};
        q_job.g0.npad  = PAD_NONE;
        if (in_bus.last_sample) begin
          q_job.g1_vld   = 1'b1;
          q_job.g1.bytes = {lo, {(2*BYTE_W){1'b0}}};
          q_job.g1.npad  = PAD_TWO;
          count_nxt      = PEND_NONE;
        end else begin
          b0_nxt    = lo;
          count_nxt = PEND_ONE;
        end
      end
      default: begin
        // nothing pending, an out-of-range count counts as none
        if (in_bus.last_sample) begin
          has_work       = 1'b1;
          q_job.g0.bytes = {hi, lo, {BYTE_W{1'b0}}};
          q_job.g0.npad  = PAD_ONE;
          count_nxt      = PEND_NONE;
        end else begin
          b0_nxt    = hi;
          b1_nxt    = lo;
          count_nxt = PEND_TWO;
        end
      end
    endcase
  end

  assign q_push = accept && has_work;

  // pending state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= PEND_NONE;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b0_r <= b0_nxt;
      b1_r <= b1_nxt;
    end
  end

endmodule

/* rtl/b64s_queue.sv */
// ----------------------------------------------------------------------------
// b64s_queue
// Short register queue of encode jobs between front and back.
// ----------------------------------------------------------------------------
module b64s_queue import b64s_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head_job,
  output logic empty
);

  job_t              mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign full     = (cnt_r == QCNT_W'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* rtl/b64s_back.sv */
// ----------------------------------------------------------------------------
// b64s_back
// Walks each queued job one character per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module b64s_back import b64s_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      job,
  input  logic      job_vld,
  output logic      job_pop,
  b64s_out_if.source out_bus
);

  logic [2:0]          idx_r;
  logic                out_vld_r;
  logic [CHAR_W-1:0]   char_r, char_nxt;
  logic                last_r, last_nxt;
  group_t              grp;
  logic [SEXTET_W-1:0] sextet;
  logic [2:0]          pad_sum;
  logic                fire;

  assign fire = job_vld && (!out_vld_r || out_bus.ready);

  // pick group and sextet for the current character
  assign grp = idx_r[2] ? job.g1 : job.g0;

  always_comb begin
    unique case (idx_r[1:0])
      2'd0:    sextet = grp.bytes[GROUP_W-1:GROUP_W-SEXTET_W];
      2'd1:    sextet = grp.bytes[GROUP_W-SEXTET_W-1:GROUP_W-2*SEXTET_W];
      2'd2:    sextet = grp.bytes[2*SEXTET_W-1:SEXTET_W];
      default: sextet = grp.bytes[SEXTET_W-1:0];
    endcase
  end

  // trailing positions of a short group are padding
  assign pad_sum  = {1'b0, idx_r[1:0]} + {1'b0, grp.npad};
  assign char_nxt = (pad_sum > 3'd3) ? PAD_CHAR : b64_char(sextet);
  assign last_nxt = (idx_r[1:0] == 2'd3) && (idx_r[2] || !job.g1_vld);
  assign job_pop  = fire && last_nxt;

  // character index and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (fire) begin
        idx_r     <= last_nxt ? 3'd0 : idx_r + 3'd1;
        out_vld_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (fire) begin
      char_r <= char_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_bus.valid     = out_vld_r;
  assign out_bus.out_char  = char_r;
  assign out_bus.last_char = last_r;

endmodule
